// File: hdl/tfp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfp_pkg
// Shared constants for the telemetry frame parser: frame layout and
// configuration register indexes.
// ---------------------------------------------------------------------------
package tfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdW = 4;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned PosW = 4;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam int unsigned MaxMessageIdDefault = 15;

  localparam logic [ByteW-1:0] StartByte = 8'h0D;
  localparam int unsigned HeaderLen = 5;
  localparam int unsigned LongPayload = 8;
  localparam int unsigned ShortPayload = 4;

  localparam logic [PosW-1:0] FrameLenNone = '0;
  localparam logic [PosW-1:0] FrameLenShort = PosW'(HeaderLen + ShortPayload);
  localparam logic [PosW-1:0] FrameLenLong = PosW'(HeaderLen + LongPayload);

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgIdentFirst = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgIdentSecond = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgIdentThird = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgLongIdA = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgLongIdB = 3'd4;

  // Reset values of the configuration registers
  localparam logic [ByteW-1:0] IdentFirstRst = 8'd73;
  localparam logic [ByteW-1:0] IdentSecondRst = 8'd84;
  localparam logic [ByteW-1:0] IdentThirdRst = 8'd66;
  localparam logic [IdW-1:0] LongIdARst = 4'd8;
  localparam logic [IdW-1:0] LongIdBRst = 4'd7;

endpackage
`default_nettype wire

// File: hdl/telemetry_frame_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// telemetry_frame_parser
// Byte-stream frame recognizer emitting id, payload and length flag.
// ---------------------------------------------------------------------------
// Takes one received byte per cycle and hunts for frames: start byte 0x0D,
// three configurable identity bytes, a message id no greater than
// MAX_MESSAGE_ID, then a payload of 8 bytes (id equal to either long id) or
// 4 bytes. Payload bytes are packed least significant first; a short
// payload leaves the upper 32 bits zero. A header byte that does not match
// is dropped and the hunt restarts on the following byte. Each completed
// frame yields one result word in the cycle after its last byte is taken.
// Throughput is one byte per cycle: the frame state is a handful of small
// registers updated by one compare and one byte-lane write per byte. The
// input stalls only while a finished result sits in the output register
// and the consumer stalls it. Configuration writes belong to idle periods.
// ---------------------------------------------------------------------------
module telemetry_frame_parser #(
  parameter int unsigned MAX_MESSAGE_ID = tfp_pkg::MaxMessageIdDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [tfp_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [tfp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // byte input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tfp_pkg::ByteW-1:0]     rx_byte_i,
  // frame output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tfp_pkg::IdW-1:0]            message_id_o,
  output logic [tfp_pkg::PayloadW-1:0]       payload_word_o,
  output logic                               payload_long_o
);
  import tfp_pkg::*;

  localparam int unsigned Lanes = PayloadW / ByteW;
  localparam int unsigned LaneW = $clog2(Lanes);

  // configuration registers
  logic [ByteW-1:0] ident_first_q, ident_second_q, ident_third_q;
  logic [IdW-1:0]   long_id_a_q, long_id_b_q;

  // frame state
  logic [PosW-1:0]     byte_pos_q, byte_pos_d;
  logic [PosW-1:0]     frame_len_q, frame_len_d;
  logic [IdW-1:0]      cur_id_q, cur_id_d;
  logic [PayloadW-1:0] payload_q, payload_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [IdW-1:0]      out_id_q;
  logic [PayloadW-1:0] out_payload_q;
  logic                out_long_q;

  logic            in_accept;
  logic            frame_done;
  logic [PosW:0]   pos;
  logic [LaneW-1:0] lane;
  logic            is_long;
  logic [PayloadW-1:0] payload_merged;

  // Hold input only while a finished frame waits and the consumer stalls.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // ---------------------------------------------------------------------
  // Configuration writes; unknown indexes are dropped.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_first_q  <= IdentFirstRst;
      ident_second_q <= IdentSecondRst;
      ident_third_q  <= IdentThirdRst;
      long_id_a_q    <= LongIdARst;
      long_id_b_q    <= LongIdBRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgIdentFirst:  ident_first_q  <= cfg_wdata_i;
        CfgIdentSecond: ident_second_q <= cfg_wdata_i;
        CfgIdentThird:  ident_third_q  <= cfg_wdata_i;
        CfgLongIdA:     long_id_a_q    <= cfg_wdata_i[IdW-1:0];
        CfgLongIdB:     long_id_b_q    <= cfg_wdata_i[IdW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Frame tracking
  // ---------------------------------------------------------------------
  // pos counts the byte now arriving, one based; one extra bit keeps a
  // corrupt count from wrapping back into the header.
  assign pos  = {1'b0, byte_pos_q} + (PosW+1)'(1);
  // Payload byte n (from 0) arrives at position HeaderLen + 1 + n.
  assign lane = LaneW'(pos - (PosW+1)'(HeaderLen + 1));

  assign is_long = (rx_byte_i == {{(ByteW-IdW){1'b0}}, long_id_a_q}) ||
                   (rx_byte_i == {{(ByteW-IdW){1'b0}}, long_id_b_q});

  // Drop the incoming byte into its lane.
  always_comb begin
    payload_merged = payload_q;
    for (int k = 0; k < Lanes; k++) begin
      if (lane == LaneW'(k)) begin
        payload_merged[k*ByteW +: ByteW] = rx_byte_i;
      end
    end
  end

  always_comb begin
    byte_pos_d  = byte_pos_q;
    frame_len_d = frame_len_q;
    cur_id_d    = cur_id_q;
    payload_d   = payload_q;
    frame_done  = 1'b0;

    if (in_accept) begin
      unique case (byte_pos_q)
        PosW'(0): begin
          // hunt for the start byte
          if (rx_byte_i == StartByte) begin
            byte_pos_d = PosW'(1);
          end else begin
            byte_pos_d = '0;
          end
        end
        PosW'(1), PosW'(2), PosW'(3): begin
          // identity bytes; drop and restart on mismatch
          if ((byte_pos_q == PosW'(1) && rx_byte_i == ident_first_q) ||
              (byte_pos_q == PosW'(2) && rx_byte_i == ident_second_q) ||
              (byte_pos_q == PosW'(3) && rx_byte_i == ident_third_q)) begin
            byte_pos_d = pos[PosW-1:0];
          end else begin
            byte_pos_d  = '0;
            frame_len_d = FrameLenNone;
            cur_id_d    = '0;
          end
        end
        PosW'(4): begin
          // message id: open the frame and size the payload
          if (rx_byte_i <= ByteW'(MAX_MESSAGE_ID)) begin
            byte_pos_d  = pos[PosW-1:0];
            frame_len_d = is_long ? FrameLenLong : FrameLenShort;
            cur_id_d    = rx_byte_i[IdW-1:0];
            payload_d   = '0;
          end else begin
            byte_pos_d  = '0;
            frame_len_d = FrameLenNone;
            cur_id_d    = '0;
          end
        end
        default: begin
          // payload bytes
          if (frame_len_q == FrameLenNone || pos > {1'b0, frame_len_q}) begin
            byte_pos_d  = '0;
            frame_len_d = FrameLenNone;
            cur_id_d    = '0;
          end else if (pos == {1'b0, frame_len_q}) begin
            frame_done  = 1'b1;
            byte_pos_d  = '0;
            frame_len_d = FrameLenNone;
            cur_id_d    = '0;
          end else begin
            byte_pos_d = pos[PosW-1:0];
            payload_d  = payload_merged;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      frame_len_q <= FrameLenNone;
      cur_id_q    <= '0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      frame_len_q <= frame_len_d;
      cur_id_q    <= cur_id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
  end

  // ---------------------------------------------------------------------
  // Output register: load on the last payload byte, clear once taken.
  // ---------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (frame_done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      out_id_q      <= cur_id_q;
      out_payload_q <= payload_merged;
      out_long_q    <= (frame_len_q == FrameLenLong);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign message_id_o   = out_id_q;
  assign payload_word_o = out_payload_q;
  assign payload_long_o = out_long_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_len_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_len_q == FrameLenNone || frame_len_q == FrameLenShort ||
    frame_len_q == FrameLenLong)
    else $error("frame length register holds an illegal value");

  a_open_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_pos_q >= PosW'(HeaderLen) |-> frame_len_q != FrameLenNone)
    else $error("payload position reached without an open frame");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_pos_q >= PosW'(HeaderLen) |-> byte_pos_q < frame_len_q)
    else $error("byte position ran past the frame length");

  a_done_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> byte_pos_q == '0 && out_valid_q)
    else $error("completed frame did not restart the hunt and post a result");

  a_short_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_long_q |-> out_payload_q[PayloadW-1:PayloadW/2] == '0)
    else $error("short frame carries nonzero upper payload bytes");

endmodule
`default_nettype wire
